### hw/rtl/kicc_pkg.sv
// ----------------------------------------------------------------------------
// kicc_pkg
// Shared types and constants for the keyed IRQ claim and fire-counter table.
// ----------------------------------------------------------------------------
package kicc_pkg;

  localparam int unsigned NumLines   = 16;
  localparam int unsigned TableDepth = 16;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned LineW  = 4;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned MaskW  = 16;
  localparam int unsigned ByteW  = 8;

  // Command codes
  localparam logic [CmdW-1:0] CmdClaim   = 3'd0;
  localparam logic [CmdW-1:0] CmdRelease = 3'd1;
  localparam logic [CmdW-1:0] CmdFire    = 3'd2;
  localparam logic [CmdW-1:0] CmdMask    = 3'd3;
  localparam logic [CmdW-1:0] CmdUnmask  = 3'd4;

  // Claim key value of each line after reset; the last line starts at zero.
  localparam logic [KeyW-1:0] KeyResetTable [TableDepth] = '{
    32'hAAFB39C0, 32'h12984C00, 32'h502EFB20, 32'hB39D82C0,
    32'hFA29E000, 32'hDCAC0210, 32'hAD830610, 32'h28903000,
    32'hB33FF000, 32'h103422A0, 32'hC720A290, 32'hFFFFAA30,
    32'hD729C200, 32'h00FCA320, 32'h0902AAF0, 32'h00000000
  };

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming transaction
    logic execute;  // read-modify-write the tables, load the result register
  } ctrl_cmd_t;

endpackage

### hw/rtl/kicc_if.sv
// ----------------------------------------------------------------------------
// kicc_if
// Valid/ready channel interfaces for the request and result transactions.
// ----------------------------------------------------------------------------
interface kicc_req_if;
  logic                           valid;
  logic                           ready;
  logic [kicc_pkg::CmdW-1:0]      cmd;
  logic [kicc_pkg::LineW-1:0]     irq_line;
  logic [kicc_pkg::KeyW-1:0]      claim_key;

  modport source (output valid, cmd, irq_line, claim_key, input ready);
  modport sink   (input valid, cmd, irq_line, claim_key, output ready);
endinterface

interface kicc_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           granted;
  logic [kicc_pkg::CountW-1:0]    fire_count;
  logic [kicc_pkg::ByteW-1:0]     mask_byte;
  logic                           secondary_sel;

  modport source (output valid, granted, fire_count, mask_byte, secondary_sel,
                  input ready);
  modport sink   (input valid, granted, fire_count, mask_byte, secondary_sel,
                  output ready);
endinterface

### hw/rtl/kicc_ctrl.sv
// ----------------------------------------------------------------------------
// kicc_ctrl
// Sequencer: capture a request, then run the table update when the result
// register can take the outcome.
// ----------------------------------------------------------------------------
module kicc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output kicc_pkg::ctrl_cmd_t   cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (out_free) begin
          cmd_o.execute = 1'b1;
          state_d       = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.execute) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/kicc_datapath.sv
// ----------------------------------------------------------------------------
// kicc_datapath
// Key table, fire counters, mask word and the registered result.
// ----------------------------------------------------------------------------
module kicc_datapath #(
  parameter int unsigned NUM_LINES = kicc_pkg::NumLines
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kicc_pkg::ctrl_cmd_t           cmd_i,
  input  logic [kicc_pkg::CmdW-1:0]     cmd_code_i,
  input  logic [kicc_pkg::LineW-1:0]    irq_line_i,
  input  logic [kicc_pkg::KeyW-1:0]     claim_key_i,
  output logic                          granted_o,
  output logic [kicc_pkg::CountW-1:0]   fire_count_o,
  output logic [kicc_pkg::ByteW-1:0]    mask_byte_o,
  output logic                          secondary_sel_o
);

  localparam int unsigned IdxW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

  // Captured request
  logic [kicc_pkg::CmdW-1:0]   cmd_q;
  logic [kicc_pkg::LineW-1:0]  line_q;
  logic [kicc_pkg::KeyW-1:0]   key_q;

  // Tables
  logic [kicc_pkg::KeyW-1:0]   keys_q [NUM_LINES];
  logic [kicc_pkg::CountW-1:0] cnt_q  [NUM_LINES];
  logic [kicc_pkg::MaskW-1:0]  mask_q, mask_d;

  // Result register
  logic                        granted_q;
  logic [kicc_pkg::CountW-1:0] count_q;
  logic [kicc_pkg::ByteW-1:0]  mask_byte_q;
  logic                        sec_q;

  logic [IdxW-1:0]             idx;
  logic                        in_range;
  logic                        line_nz;
  logic [kicc_pkg::KeyW-1:0]   rd_key, key_dec, key_d;
  logic [kicc_pkg::CountW-1:0] rd_cnt, cnt_d;
  logic [kicc_pkg::MaskW-1:0]  line_bit;
  logic                        granted_d;
  logic                        secondary;

  assign idx       = IdxW'(line_q);
  assign in_range  = 5'(line_q) < 5'(NUM_LINES);
  assign line_nz   = line_q != '0;
  assign rd_key    = in_range ? keys_q[idx] : '0;
  assign rd_cnt    = in_range ? cnt_q[idx]  : '0;
  assign key_dec   = rd_key - 32'd1;
  assign line_bit  = kicc_pkg::MaskW'(1) << line_q;
  assign secondary = line_q[kicc_pkg::LineW-1];

  always_comb begin
    key_d     = rd_key;
    cnt_d     = rd_cnt;
    mask_d    = mask_q;
    granted_d = 1'b0;
    if (in_range) begin
      unique case (cmd_q)
        kicc_pkg::CmdClaim: begin
          if (line_nz && rd_key == key_q) begin
            cnt_d     = '0;
            key_d     = rd_key + 32'd1;
            mask_d    = mask_q & ~line_bit;
            granted_d = 1'b1;
          end
        end
        kicc_pkg::CmdRelease: begin
          if (line_nz && key_dec == key_q) begin
            key_d     = key_dec;
            mask_d    = mask_q | line_bit;
            granted_d = 1'b1;
          end
        end
        kicc_pkg::CmdFire: begin
          if ((mask_q & line_bit) == '0) begin
            cnt_d = rd_cnt + 16'd1;
          end
        end
        kicc_pkg::CmdMask:   mask_d = mask_q | line_bit;
        kicc_pkg::CmdUnmask: mask_d = mask_q & ~line_bit;
        default: ;
      endcase
    end
  end

  // Request capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= cmd_code_i;
      line_q <= irq_line_i;
      key_q  <= claim_key_i;
    end
  end

  // Architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        keys_q[i] <= kicc_pkg::KeyResetTable[i];
        cnt_q[i]  <= '0;
      end
      mask_q <= '0;
    end else if (cmd_i.execute) begin
      if (in_range) begin
        keys_q[idx] <= key_d;
        cnt_q[idx]  <= cnt_d;
      end
      mask_q <= mask_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      granted_q   <= granted_d;
      count_q     <= cnt_d;
      mask_byte_q <= secondary ? mask_d[15:8] : mask_d[7:0];
      sec_q       <= secondary;
    end
  end

  assign granted_o       = granted_q;
  assign fire_count_o    = count_q;
  assign mask_byte_o     = mask_byte_q;
  assign secondary_sel_o = sec_q;

endmodule

### hw/rtl/keyed_irq_claim_counter_table_top.sv
// ----------------------------------------------------------------------------
// keyed_irq_claim_counter_table_top
// Keyed interrupt-line claim table with per-line fire counters and mask word.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                      | handshake
//  --------+-----+----------------------------------------------+-----------
//  in_i    | in  | cmd[2:0], irq_line[3:0], claim_key[31:0]     | valid/ready
//  out_o   | out | granted, fire_count[15:0], mask_byte[7:0],   | valid/ready
//          |     | secondary_sel                                |
//
//  Each transaction first captures the request, then runs the
//  read-modify-write of the line's key, counter and the mask word.
//  The result sits in an output register, so the next request is accepted
//  while a result is still waiting on out_o.
//  If the output register is still full when the update is due, the update
//  waits; in_i stays not ready until it runs.
//  Reset is asynchronous, active low; the key table loads its fixed values.
//
module keyed_irq_claim_counter_table_top #(
  parameter int unsigned NUM_LINES = kicc_pkg::NumLines
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  kicc_req_if.sink     in_i,
  kicc_rsp_if.source   out_o
);

  kicc_pkg::ctrl_cmd_t ctrl_cmd;

  // Sequencer: owns the handshakes and the result-valid flag
  kicc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (ctrl_cmd)
  );

  // Tables and result payload
  kicc_datapath #(
    .NUM_LINES (NUM_LINES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .cmd_code_i      (in_i.cmd),
    .irq_line_i      (in_i.irq_line),
    .claim_key_i     (in_i.claim_key),
    .granted_o       (out_o.granted),
    .fire_count_o    (out_o.fire_count),
    .mask_byte_o     (out_o.mask_byte),
    .secondary_sel_o (out_o.secondary_sel)
  );

endmodule

### verif/tb_keyed_irq_claim_counter_table_top.sv
// ----------------------------------------------------------------------------
// tb_keyed_irq_claim_counter_table_top
// Self-checking bench for the keyed IRQ claim and fire-counter table. A
// directed run covers line zero, key wrap in claim and release, masked fires
// and the spare command codes. Random claim/release/fire/mask traffic follows
// in three idling mixes, then a back-to-back fire burst on one line.
// Every result is compared field by field against an in-bench model.
// ----------------------------------------------------------------------------
module tb_keyed_irq_claim_counter_table_top;
  import kicc_pkg::*;

  // Spare command codes: the block must leave all state alone for these
  localparam logic [CmdW-1:0] CmdSpareLo  = 3'd5;
  localparam logic [CmdW-1:0] CmdSpareMid = 3'd6;
  localparam logic [CmdW-1:0] CmdSpareHi  = 3'd7;

  localparam int unsigned RandPerPhase = 260;
  localparam int unsigned WrapLine     = 3;
  localparam int unsigned WrapBurst    = 20;     // back-to-back fires on one line
  localparam int unsigned HoldAtResult = 120;    // long receiver hold-off starts here
  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned TailCycles   = 20;
  localparam int unsigned QuietLimit   = 5000;   // cycles without any transaction

  // Idle percentages per traffic phase: sender-heavy, receiver-heavy, none
  localparam int unsigned SendIdlePct [3] = '{9, 55, 0};
  localparam int unsigned RecvIdlePct [3] = '{55, 9, 0};

  // How the key of a request is chosen when it goes on the bus
  typedef enum logic [1:0] {
    KeyAsGiven,   // use the stored random key
    KeyCurrent,   // line's current key (a claim that should be granted)
    KeyPrevious   // line's current key minus one (a release that should be granted)
  } key_sel_e;

  typedef struct {
    logic [CmdW-1:0]  cmd;
    logic [LineW-1:0] line;
    logic [KeyW-1:0]  key;
    key_sel_e         ksel;
    int unsigned      phase;
    bit               drain;   // hold this request until all results are back
  } irq_op_t;

  typedef struct packed {
    logic              granted;
    logic [CountW-1:0] fire_count;
    logic [ByteW-1:0]  mask_byte;
    logic              secondary_sel;
  } irq_rsp_t;

  logic clk;
  logic rst_n;

  kicc_req_if req_if ();
  kicc_rsp_if rsp_if ();

  keyed_irq_claim_counter_table_top uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if.sink),
    .out_o  (rsp_if.source)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Table model: keys, counters and the mask word as the block should hold them
  // --------------------------------------------------------------------------
  logic [KeyW-1:0]   line_key_m  [TableDepth];
  logic [CountW-1:0] fire_cnt_m  [TableDepth];
  logic [MaskW-1:0]  mask_word_m;

  int unsigned grants_cnt;
  int unsigned refusals_cnt;
  int unsigned masked_fires_cnt;
  int unsigned wraps_cnt;

  irq_op_t     pending_op_q [$];   // requests not yet on the bus
  irq_rsp_t    expected_rsp_q [$]; // results owed by the block, oldest first
  irq_op_t     active_op;          // request currently offered
  int unsigned ops_done;           // driver-local count of accepted requests
  int unsigned ops_accepted;       // registered copy for the monitor
  int unsigned results_cnt;        // monitor-local count of matched results
  int unsigned results_seen;       // registered copy for the driver and the end check
  int unsigned phase_q;
  int unsigned mismatches;

  // Applies one accepted request to the model and returns the result it owes.
  function automatic irq_rsp_t irq_table_update(irq_op_t op);
    irq_rsp_t         rsp;
    logic [MaskW-1:0] line_bit;
    logic [KeyW-1:0]  prev_key;
    line_bit = '0;
    line_bit[op.line] = 1'b1;
    rsp = '0;
    if (op.line < NumLines) begin
      prev_key = line_key_m[op.line] - 1'b1;   // wraps modulo 2^32
      case (op.cmd)
        CmdClaim: begin
          if (op.line != '0 && line_key_m[op.line] == op.key) begin
            fire_cnt_m[op.line] = '0;
            line_key_m[op.line] = line_key_m[op.line] + 1'b1;
            mask_word_m = mask_word_m & ~line_bit;
            rsp.granted = 1'b1;
          end
        end
        CmdRelease: begin
          if (op.line != '0 && prev_key == op.key) begin
            mask_word_m = mask_word_m | line_bit;
            line_key_m[op.line] = prev_key;
            rsp.granted = 1'b1;
          end
        end
        CmdFire: begin
          if ((mask_word_m & line_bit) == '0) begin
            if (fire_cnt_m[op.line] == '1) wraps_cnt++;
            fire_cnt_m[op.line] = fire_cnt_m[op.line] + 1'b1;
          end else begin
            masked_fires_cnt++;
          end
        end
        CmdMask:   mask_word_m = mask_word_m | line_bit;
        CmdUnmask: mask_word_m = mask_word_m & ~line_bit;
        default: ;
      endcase
      rsp.fire_count = fire_cnt_m[op.line];
    end
    if (op.cmd == CmdClaim || op.cmd == CmdRelease) begin
      if (rsp.granted) grants_cnt++;
      else refusals_cnt++;
    end
    rsp.secondary_sel = op.line[LineW-1];
    rsp.mask_byte = rsp.secondary_sel ? mask_word_m[15:8] : mask_word_m[7:0];
    return rsp;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void add_op(logic [CmdW-1:0] cmd, logic [LineW-1:0] line,
                                 logic [KeyW-1:0] key, key_sel_e ksel);
    irq_op_t op;
    op.cmd   = cmd;
    op.line  = line;
    op.key   = key;
    op.ksel  = ksel;
    op.phase = 0;
    op.drain = 1'b0;
    pending_op_q.push_back(op);
  endfunction

  // Mostly well-formed traffic: claims with the live key, releases with the
  // live key minus one, so lines cycle through claim/release and keys drift.
  function automatic irq_op_t random_op(int unsigned phase);
    irq_op_t     op;
    int unsigned pick;
    int unsigned how;
    op.phase = phase;
    op.drain = 1'b0;
    op.ksel  = KeyAsGiven;
    op.line  = LineW'($urandom_range(TableDepth - 1, 0));
    op.key   = $urandom();
    if ($urandom_range(7, 0) == 0) op.key = {KeyW{op.key[0]}};
    pick = $urandom_range(99, 0);
    how  = $urandom_range(9, 0);
    if (pick < 25) begin
      op.cmd  = CmdClaim;
      op.ksel = (how < 7) ? KeyCurrent : (how == 7) ? KeyPrevious : KeyAsGiven;
    end else if (pick < 45) begin
      op.cmd  = CmdRelease;
      op.ksel = (how < 7) ? KeyPrevious : (how == 7) ? KeyCurrent : KeyAsGiven;
    end else if (pick < 75) begin
      op.cmd = CmdFire;
    end else if (pick < 85) begin
      op.cmd = CmdMask;
    end else if (pick < 95) begin
      op.cmd = CmdUnmask;
    end else begin
      op.cmd = CmdW'($urandom_range(CmdSpareHi, CmdSpareLo));
    end
    return op;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers requests from the pending queue, models each transaction
  // at the edge it is accepted, and resolves live keys just before offering.
  // --------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : drive_requests
    irq_op_t op;
    bit      offer;
    if (!rst_n) begin
      req_if.valid     <= 1'b0;
      req_if.cmd       <= '0;
      req_if.irq_line  <= '0;
      req_if.claim_key <= '0;
      ops_accepted     <= 0;
      phase_q          <= 0;
      ops_done          = 0;
      mask_word_m       = '0;
      for (int i = 0; i < TableDepth; i++) begin
        line_key_m[i] = KeyResetTable[i];
        fire_cnt_m[i] = '0;
      end
    end else begin
      offer = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        expected_rsp_q.push_back(irq_table_update(active_op));
        ops_done++;
        offer = 1'b0;
      end
      // A drain request waits until every owed result has come back;
      // results_seen is the registered count, so this is race free.
      if (!offer && pending_op_q.size() != 0) begin
        op = pending_op_q[0];
        if ((!op.drain || results_seen == ops_done) &&
            $urandom_range(99, 0) >= SendIdlePct[op.phase]) begin
          case (op.ksel)
            KeyCurrent:  op.key = line_key_m[op.line];
            KeyPrevious: op.key = line_key_m[op.line] - 1'b1;
            default: ;
          endcase
          void'(pending_op_q.pop_front());
          active_op = op;
          offer     = 1'b1;
        end
      end
      req_if.valid <= offer;
      if (offer) begin
        req_if.cmd       <= active_op.cmd;
        req_if.irq_line  <= active_op.line;
        req_if.claim_key <= active_op.key;
        phase_q          <= active_op.phase;
      end
      ops_accepted <= ops_done;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result transaction against the oldest expectation
  // and drives ready, including one long hold-off so the block backs up.
  // --------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : collect_results
    irq_rsp_t    want;
    int unsigned hold_left;
    bit          hold_done;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      results_seen <= 0;
      results_cnt   = 0;
      hold_left     = 0;
      hold_done     = 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        // ops_accepted is last edge's count, so the expectation is already queued
        if (results_cnt >= ops_accepted) begin
          $display("%0t: result with nothing expected: granted %0b count %0h mask %0h sec %0b",
                   $time, rsp_if.granted, rsp_if.fire_count, rsp_if.mask_byte,
                   rsp_if.secondary_sel);
          mismatches++;
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("granted", 32'(want.granted), 32'(rsp_if.granted));
          check_field("fire_count", 32'(want.fire_count), 32'(rsp_if.fire_count));
          check_field("mask_byte", 32'(want.mask_byte), 32'(rsp_if.mask_byte));
          check_field("secondary_sel", 32'(want.secondary_sel),
                      32'(rsp_if.secondary_sel));
          results_cnt++;
        end
      end
      if (!hold_done && results_cnt >= HoldAtResult) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99, 0) >= RecvIdlePct[phase_q]);
      end
      results_seen <= results_cnt;
    end
  end

  // Watchdog: ends the run if neither channel moves for too long
  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if (!rst_n) begin
      quiet = 0;
    end else begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
        $display("%0t: no transaction for %0d cycles, %0d of %0d results back",
                 $time, quiet, results_seen, ops_done);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : run_test
    irq_op_t     op;
    int unsigned total;
    rst_n            = 1'b0;
    mismatches       = 0;
    grants_cnt       = 0;
    refusals_cnt     = 0;
    masked_fires_cnt = 0;
    wraps_cnt        = 0;

    // Line zero: claim and release refused even with the right key
    add_op(CmdClaim,   4'd0, '0, KeyCurrent);
    add_op(CmdRelease, 4'd0, '0, KeyPrevious);
    add_op(CmdFire,    4'd0, '0, KeyAsGiven);
    add_op(CmdMask,    4'd0, '0, KeyAsGiven);
    add_op(CmdFire,    4'd0, '0, KeyAsGiven);   // masked, counter holds
    add_op(CmdUnmask,  4'd0, '0, KeyAsGiven);
    // Last line starts at key zero: walk the key through the 2^32 wrap
    add_op(CmdClaim,   4'd15, '0, KeyCurrent);  // 0 -> 1
    add_op(CmdRelease, 4'd15, '0, KeyPrevious); // 1 -> 0, masked
    add_op(CmdFire,    4'd15, '0, KeyAsGiven);  // masked fire
    add_op(CmdRelease, 4'd15, '0, KeyPrevious); // compare against 0 - 1
    add_op(CmdClaim,   4'd15, '0, KeyCurrent);  // all-ones -> 0
    // Wrong keys, field extremes
    add_op(CmdClaim,   4'd9,  '0, KeyAsGiven);
    add_op(CmdClaim,   4'd11, '1, KeyAsGiven);
    add_op(CmdRelease, 4'd11, '0, KeyCurrent);  // current key is not current - 1
    add_op(CmdClaim,   4'd1,  '0, KeyCurrent);
    // Both controllers' mask bytes
    add_op(CmdFire,    4'd8,  '0, KeyAsGiven);
    add_op(CmdMask,    4'd8,  '0, KeyAsGiven);
    add_op(CmdMask,    4'd7,  '0, KeyAsGiven);
    add_op(CmdUnmask,  4'd8,  '0, KeyAsGiven);
    // Spare command codes
    add_op(CmdSpareLo,  4'd4,  '0, KeyAsGiven);
    add_op(CmdSpareMid, 4'd12, '0, KeyCurrent);
    add_op(CmdSpareHi,  4'd15, '1, KeyAsGiven);
    add_op(CmdFire,     4'd15, '0, KeyAsGiven);

    // Random traffic in three idling mixes; each later mix starts from a drain
    for (int p = 0; p < 3; p++) begin
      for (int n = 0; n < RandPerPhase; n++) begin
        op = random_op(p);
        op.drain = (n == 0 && p != 0);
        pending_op_q.push_back(op);
      end
    end

    // Full-rate fire burst on one unmasked line
    op = random_op(2);
    op.cmd  = CmdUnmask;
    op.line = LineW'(WrapLine);
    pending_op_q.push_back(op);
    op.cmd = CmdFire;
    for (int n = 0; n < WrapBurst; n++) pending_op_q.push_back(op);

    total = pending_op_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (results_seen != total) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("Run covered %0d transactions: %0d claim/release grants, %0d refusals,",
             total, grants_cnt, refusals_cnt);
    $display("  %0d fires on masked lines, %0d counter wraps, one long receiver hold-off.",
             masked_fires_cnt, wraps_cnt);
    if (mismatches == 0 && expected_rsp_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
